// File: sv/assert_macros.svh
// assertion macros shared by the record delta encoder rtl
// expects clk and arst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// condition must hold at every edge out of reset
`define RDE_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("rde assertion failed");
// consequent must hold in the same cycle as the antecedent
`define RDE_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rde assertion failed");
`else
`define RDE_ASSERT_ALWAYS(lbl, cond)
`define RDE_ASSERT_IMPLY(lbl, ante, cons)
`endif
`endif

// File: sv/rde_pkg.sv
// types, constants and field tables of the record delta encoder
// no dependencies
package rde_pkg;

	localparam int FIELD_COUNT      = 44;
	localparam int MASK_BYTES_DEF   = 6;
	localparam int OVERFLOW_BIT_DEF = 47;
	localparam int YOFFSET_FIELD    = 19;
	localparam int SUB_LOW_FIELDS   = 12;
	localparam int DELTA1_MIN       = -128;
	localparam int DELTA1_MAX       = 127;
	localparam int DELTA2_MIN       = -32768;
	localparam int DELTA2_MAX       = 32767;
	localparam logic [7:0] MAX_LEN_RESET = 8'hFF;

	// absolute width in bytes of each field
	localparam logic [2:0] ABS_W [FIELD_COUNT] = '{
		4,4,4,4,4,4, 2,2,2,2, 4,4, 1,1,1, 2,2,2,2, 4,
		1,1,1,1,1,1,1, 4,4, 1, 2,2, 1,1,1,1,1,1,1,1, 4,4,4, 1};

	// narrow delta width, zero when the field is sent absolute only
	localparam logic [1:0] DLT_W [FIELD_COUNT] = '{
		2,2,2,2,2,2, 1,1,1,1, 2,2, 0,0,0, 0,0,0,0, 2,
		0,0,0,0,0,0,0, 0,0, 0, 0,0, 0,0,0,0,0,0,0,0, 0,0,0, 0};

	// fields held as sign-extended 16-bit values
	localparam logic SHORT_F [FIELD_COUNT] = '{
		0,0,0,0,0,0, 0,0,0,0, 0,0, 1,1,1, 1,1,0,1, 0,
		1,1,0,1,1,1,1, 0,0, 1, 1,1, 1,1,1,1,0,1,1,0, 0,0,0, 1};

	typedef struct packed {
		logic signed [31:0] field_value;
		logic               full_frame;
		logic [7:0]         player_index;
	} src_t;

	typedef struct packed {
		logic [63:0] packet_bytes;
		logic [3:0]  byte_count;
		logic        last_chunk;
		logic        status;
	} res_t;

	// one packet byte handed to the chunk packer
	typedef struct packed {
		logic       vld;
		logic       last;
		logic       fail;
		logic [7:0] data;
	} byte_req_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_SCAN_RD,
		ST_SCAN_EV,
		ST_CHECK,
		ST_HDR,
		ST_DRD,
		ST_DBYTE
	} state_t;

endpackage

// File: sv/rde_packer.sv
// gathers packet bytes into 8-byte little-endian chunks with an output register
// depends on rde_pkg
module rde_packer import rde_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  byte_req_t req,
	output logic      take,
	output logic      res_valid,
	input  logic      res_ready,
	output res_t      res_data
);

	logic [63:0] chunk_q;
	logic [2:0]  cnt_q;
	logic        free;
	logic        done;
	logic [63:0] merged;

	// a request that closes a chunk needs the output register free
	always_comb begin
		free   = !res_valid || res_ready;
		done   = req.fail || req.last || (cnt_q == 3'd7);
		take   = (req.vld || req.fail) && (free || !done);
		merged = chunk_q | (64'(req.data) << {cnt_q, 3'b000});
	end

	// chunk assembly and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_q   <= '0;
			cnt_q     <= '0;
			res_valid <= 1'b0;
		end else begin
			if (take && done)
				res_valid <= 1'b1;
			else if (res_valid && res_ready)
				res_valid <= 1'b0;
			if (take) begin
				if (done) begin
					chunk_q   <= '0;
					cnt_q     <= '0;
				end else begin
					chunk_q <= merged;
					cnt_q   <= cnt_q + 3'd1;
				end
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (take && done) begin
			if (req.fail) begin
				res_data.packet_bytes <= '0;
				res_data.byte_count   <= '0;
				res_data.last_chunk   <= 1'b1;
				res_data.status       <= 1'b1;
			end else begin
				res_data.packet_bytes <= merged;
				res_data.byte_count   <= 4'({1'b0, cnt_q}) + 4'd1;
				res_data.last_chunk   <= req.last;
				res_data.status       <= 1'b0;
			end
		end
	end

endmodule

// File: sv/record_delta_encoder.sv
// top level of the record delta encoder: field store, scan sequencer, header and data bytes
// depends on rde_pkg, rde_packer and assert_macros.svh
//
//  channel | signals                      | request
//  src     | src_valid src_ready src_data | one field value, keyframe flag, player
//  res     | res_valid res_ready res_data | one packet chunk of up to eight bytes
//  cfg     | cfg_we cfg_wdata             | max_length write, no wait
//
// fields load one per accepted src transfer; the last one starts a scan that reads each
// field from the two-port record store and sizes it in the shared subtract-and-compare
// unit, then a length check, the header bytes, and per field up to the last data byte one
// emit store read plus its data bytes (an idle step when the field sends nothing)
// closing a chunk needs a free output register, so a full one stalls the sequencer
// reset needs no clearing pass: per-entry valid bits make the previous record read as zero
`include "assert_macros.svh"
module record_delta_encoder import rde_pkg::*; #(
	parameter int MASK_BYTES   = MASK_BYTES_DEF,
	parameter int OVERFLOW_BIT = OVERFLOW_BIT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       src_valid,
	output logic       src_ready,
	input  src_t       src_data,
	output logic       res_valid,
	input  logic       res_ready,
	output res_t       res_data,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata
);

	localparam int RA_W = $clog2(2 * FIELD_COUNT);
	localparam int FI_W = $clog2(FIELD_COUNT);
	localparam logic [RA_W-1:0] FC_OFS   = RA_W'(FIELD_COUNT);
	localparam logic [FI_W-1:0] LAST_FLD = FI_W'(FIELD_COUNT - 1);

	state_t state_q, state_d;

	logic [FI_W-1:0] idx_q;
	logic            kf_q;
	logic [7:0]      player_q;
	logic            bank_q;
	logic [7:0]      maxlen_q;

	logic [31:0]       rec_mem [2*FIELD_COUNT];
	logic [2*FIELD_COUNT-1:0] rec_vld_q;
	logic [31:0]       pend_rd_q, prev_rd_q;

	logic [31:0] emit_val [FIELD_COUNT];
	logic [2:0]  emit_w   [FIELD_COUNT];
	logic [31:0] ev_rd_q;
	logic [2:0]  ew_rd_q;

	logic [FI_W-1:0]      cnt_q;
	logic [1:0]           b_q;
	logic [3:0]           hp_q;
	logic [6:0]           left_q;
	logic [6:0]           len_q;
	logic [FIELD_COUNT-1:0] mask_q;
	logic                 ovf_q;
	logic [12:0]          sub_q;

	logic              accept;
	logic [31:0]       in_val;
	logic [RA_W-1:0]   wr_addr, pend_addr, prev_addr;
	logic signed [32:0] sc_diff;
	logic              sc_chg, sc_fit, sc_ovf;
	logic [2:0]        sc_w;
	logic [31:0]       sc_val;
	logic [3:0]        hdr_len;
	logic [6:0]        tot_len;
	logic              too_long;
	logic [63:0]       mask_tx;
	logic [2:0]        mbi;
	logic [7:0]        hdr_byte;
	logic [7:0]        dat_byte;
	logic              is_last;
	logic              take;
	byte_req_t         breq;

	// field intake and store addressing
	always_comb begin
		accept    = src_valid && src_ready;
		in_val    = SHORT_F[idx_q] ? {{16{src_data.field_value[15]}}, src_data.field_value[15:0]}
		                           : src_data.field_value;
		wr_addr   = bank_q ? RA_W'(idx_q) : RA_W'(idx_q) + FC_OFS;
		pend_addr = bank_q ? RA_W'(cnt_q) : RA_W'(cnt_q) + FC_OFS;
		prev_addr = bank_q ? RA_W'(cnt_q) + FC_OFS : RA_W'(cnt_q);
	end

	// shared subtract and range compare for one field
	always_comb begin
		sc_diff = signed'({pend_rd_q[31], pend_rd_q}) - signed'({prev_rd_q[31], prev_rd_q});
		sc_chg  = (pend_rd_q != prev_rd_q);
		if (DLT_W[cnt_q] == 2'd1)
			sc_fit = (sc_diff >= signed'(33'(DELTA1_MIN))) && (sc_diff <= signed'(33'(DELTA1_MAX)));
		else
			sc_fit = (sc_diff >= signed'(33'(DELTA2_MIN))) && (sc_diff <= signed'(33'(DELTA2_MAX)));
		sc_ovf = 1'b0;
		sc_val = pend_rd_q;
		sc_w   = ABS_W[cnt_q];
		if (!kf_q) begin
			if (!sc_chg) begin
				sc_w = 3'd0;
			end else if (DLT_W[cnt_q] != 2'd0) begin
				if (sc_fit) begin
					sc_w   = 3'({1'b0, DLT_W[cnt_q]});
					sc_val = sc_diff[31:0];
				end else begin
					sc_ovf = 1'b1;
				end
			end
		end
	end

	// packet length and header bytes
	always_comb begin
		hdr_len  = kf_q ? 4'd1 : 4'd1 + 4'(MASK_BYTES) + (ovf_q ? 4'd2 : 4'd0);
		tot_len  = 7'(hdr_len) + len_q;
		too_long = ({1'b0, tot_len} > maxlen_q);
		mask_tx  = 64'(mask_q) | (64'(ovf_q) << OVERFLOW_BIT);
		mbi      = 3'(hp_q - 4'd1);
		if (hp_q == 4'd0)
			hdr_byte = player_q;
		else if (hp_q <= 4'(MASK_BYTES))
			hdr_byte = mask_tx[{mbi, 3'b000} +: 8];
		else if (hp_q == 4'(MASK_BYTES + 1))
			hdr_byte = sub_q[7:0];
		else
			hdr_byte = {3'b000, sub_q[12:8]};
		dat_byte = 8'(ev_rd_q >> {b_q, 3'b000});
		is_last  = (left_q == 7'd1);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD:    if (accept && idx_q == LAST_FLD) state_d = ST_SCAN_RD;
			ST_SCAN_RD: state_d = ST_SCAN_EV;
			ST_SCAN_EV: state_d = (cnt_q == LAST_FLD) ? ST_CHECK : ST_SCAN_RD;
			ST_CHECK: begin
				if (!too_long)
					state_d = ST_HDR;
				else if (take)
					state_d = ST_LOAD;
			end
			ST_HDR: begin
				if (take) begin
					if (is_last)
						state_d = ST_LOAD;
					else if (hp_q == hdr_len - 4'd1)
						state_d = ST_DRD;
				end
			end
			ST_DRD:     state_d = ST_DBYTE;
			ST_DBYTE: begin
				if (ew_rd_q == 3'd0)
					state_d = ST_DRD;
				else if (take) begin
					if (is_last)
						state_d = ST_LOAD;
					else if (3'({1'b0, b_q}) == ew_rd_q - 3'd1)
						state_d = ST_DRD;
				end
			end
			default:    state_d = ST_LOAD;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		src_ready = (state_q == ST_LOAD);
		breq      = '0;
		breq.last = is_last;
		unique case (state_q)
			ST_CHECK: breq.fail = too_long;
			ST_HDR: begin
				breq.vld  = 1'b1;
				breq.data = hdr_byte;
			end
			ST_DBYTE: begin
				breq.vld  = (ew_rd_q != 3'd0);
				breq.data = dat_byte;
			end
			default: breq.vld = 1'b0;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			idx_q     <= '0;
			kf_q      <= 1'b0;
			player_q  <= '0;
			bank_q    <= 1'b0;
			maxlen_q  <= MAX_LEN_RESET;
			rec_vld_q <= '0;
			cnt_q     <= '0;
			b_q       <= '0;
			hp_q      <= '0;
			left_q    <= '0;
			len_q     <= '0;
			mask_q    <= '0;
			ovf_q     <= 1'b0;
			sub_q     <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we)
				maxlen_q <= cfg_wdata;
			unique case (state_q)
				ST_LOAD: begin
					if (accept) begin
						rec_vld_q[wr_addr] <= 1'b1;
						if (idx_q == '0) begin
							kf_q     <= src_data.full_frame;
							player_q <= src_data.player_index;
						end
						if (idx_q == LAST_FLD) begin
							idx_q  <= '0;
							cnt_q  <= '0;
							len_q  <= '0;
							mask_q <= '0;
							ovf_q  <= 1'b0;
							sub_q  <= '0;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				ST_SCAN_EV: begin
					len_q         <= len_q + 7'(sc_w);
					mask_q[cnt_q] <= sc_chg && !kf_q;
					if (sc_ovf) begin
						ovf_q <= 1'b1;
						if (cnt_q < FI_W'(SUB_LOW_FIELDS))
							sub_q[4'(cnt_q)] <= 1'b1;
						else if (cnt_q == FI_W'(YOFFSET_FIELD))
							sub_q[12] <= 1'b1;
					end
					cnt_q <= (cnt_q == LAST_FLD) ? '0 : cnt_q + 1'b1;
				end
				ST_CHECK: begin
					left_q <= tot_len;
					hp_q   <= '0;
					cnt_q  <= '0;
					if (!too_long)
						bank_q <= ~bank_q;
				end
				ST_HDR: begin
					if (take) begin
						hp_q   <= hp_q + 4'd1;
						left_q <= left_q - 7'd1;
					end
				end
				ST_DRD: b_q <= '0;
				ST_DBYTE: begin
					if (ew_rd_q == 3'd0) begin
						cnt_q <= cnt_q + 1'b1;
					end else if (take) begin
						left_q <= left_q - 7'd1;
						if (3'({1'b0, b_q}) == ew_rd_q - 3'd1)
							cnt_q <= cnt_q + 1'b1;
						else
							b_q <= b_q + 2'd1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// record store: pending and previous banks, swapped on a sent packet
	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD && accept)
			rec_mem[wr_addr] <= in_val;
		if (state_q == ST_SCAN_RD) begin
			pend_rd_q <= rec_mem[pend_addr];
			prev_rd_q <= rec_vld_q[prev_addr] ? rec_mem[prev_addr] : '0;
		end
	end

	// emit store: value and byte width of each field
	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN_EV) begin
			emit_val[cnt_q] <= sc_val;
			emit_w[cnt_q]   <= sc_w;
		end
		if (state_q == ST_DRD) begin
			ev_rd_q <= emit_val[cnt_q];
			ew_rd_q <= emit_w[cnt_q];
		end
	end

	rde_packer u_packer (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (breq),
		.take      (take),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data)
	);

	// checks
	`RDE_ASSERT_IMPLY(a_fail_shape, res_valid && res_data.status, res_data.last_chunk && res_data.byte_count == 4'd0)
	`RDE_ASSERT_IMPLY(a_full_chunk, res_valid && !res_data.last_chunk, res_data.byte_count == 4'd8)
	`RDE_ASSERT_IMPLY(a_bytes_left, state_q == ST_HDR || state_q == ST_DBYTE, left_q != 7'd0)

endmodule
